// ===== src/bounded_deque_with_search_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded deque
// Clocked assertion wrappers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BDQ_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define BDQ_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

// ===== src/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and codes shared by the deque controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bdq_pkg;

    typedef enum logic [2:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_SEARCH     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    localparam int unsigned ACT_W  = 3;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned OCC_W  = 5;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned OUT_W  = 8;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic srch;
        logic done;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== src/bdq_dp.sv =====
// ----------------------------------------------------------------------------
// bdq_dp
// Ring store, front index, occupancy count, search scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_deque_with_search_assert.svh"

module bdq_dp #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [bdq_pkg::ACT_W-1:0]       i_action,
    input  wire logic signed [bdq_pkg::WORD_W-1:0] i_value,
    input  wire bdq_pkg::t_dp_cmd                i_cmd,
    output bdq_pkg::t_dp_stat                    o_stat,
    output logic [bdq_pkg::STAT_W-1:0]           o_status,
    output logic                                 o_found,
    output logic [bdq_pkg::OCC_W-1:0]            o_occupancy
);

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    logic [bdq_pkg::WORD_W-1:0] r_mem [CAPACITY];

    logic [IDX_W-1:0]           r_front,     n_front;
    logic [CNT_W-1:0]           r_count,     n_count;
    logic [CNT_W-1:0]           r_scan_k;
    logic [IDX_W-1:0]           r_scan_addr;
    logic                       r_rd_vld;
    logic [bdq_pkg::WORD_W-1:0] r_rd_data;
    logic [bdq_pkg::WORD_W-1:0] r_key;
    logic                       r_hit;
    logic [bdq_pkg::STAT_W-1:0] r_status,    n_status;
    logic                       r_found;
    logic [bdq_pkg::OCC_W-1:0]  r_occ;

    bdq_pkg::t_action           act;
    logic                       full;
    logic                       empty;
    logic                       mem_we;
    logic [IDX_W-1:0]           mem_waddr;
    logic [IDX_W-1:0]           front_dec;
    logic [IDX_W-1:0]           front_inc;
    logic [IDX_W-1:0]           scan_inc;
    logic [CNT_W:0]             back_sum;
    logic [CNT_W:0]             back_wrap;
    logic [IDX_W-1:0]           back_idx;
    logic                       issue;
    logic                       hit_now;
    logic                       scan_done;
    logic [CNT_W+bdq_pkg::OCC_W-1:0] occ_wide_n;
    logic [CNT_W+bdq_pkg::OCC_W-1:0] occ_wide_r;

    assign act   = bdq_pkg::t_action'(i_action);
    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    assign front_dec = (r_front == '0) ? IDX_W'(CAPACITY - 1) : r_front - IDX_W'(1);
    assign front_inc = (r_front == IDX_W'(CAPACITY - 1)) ? '0 : r_front + IDX_W'(1);
    assign scan_inc  = (r_scan_addr == IDX_W'(CAPACITY - 1)) ? '0 : r_scan_addr + IDX_W'(1);

    assign back_sum  = (CNT_W+1)'(r_front) + (CNT_W+1)'(r_count);
    assign back_wrap = (back_sum >= (CNT_W+1)'(CAPACITY)) ?
                       back_sum - (CNT_W+1)'(CAPACITY) : back_sum;
    assign back_idx  = back_wrap[IDX_W-1:0];

    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_status  = bdq_pkg::ST_DONE;
        mem_we    = 1'b0;
        mem_waddr = back_idx;
        case (act)
            bdq_pkg::ACT_PUSH_FRONT: begin
                if (full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_front   = front_dec;
                    n_count   = r_count + CNT_W'(1);
                    mem_we    = 1'b1;
                    mem_waddr = front_dec;
                end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
                if (full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    mem_we  = 1'b1;
                end
            end
            bdq_pkg::ACT_POP_FRONT: begin
                if (empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_front = front_inc;
                    n_count = r_count - CNT_W'(1);
                end
            end
            bdq_pkg::ACT_POP_BACK: begin
                if (empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign issue     = i_cmd.scan && !r_hit && (r_scan_k != r_count);
    assign hit_now   = r_rd_vld && (r_rd_data == r_key);
    assign scan_done = r_hit || hit_now || ((r_scan_k == r_count) && !r_rd_vld);

    assign occ_wide_n = {{bdq_pkg::OCC_W{1'b0}}, n_count};
    assign occ_wide_r = {{bdq_pkg::OCC_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && mem_we) begin
            r_mem[mem_waddr] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_data <= r_mem[r_scan_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_count  <= '0;
            r_scan_k <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else if (i_cmd.load) begin
            r_front  <= n_front;
            r_count  <= n_count;
            r_scan_k <= '0;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
        end else if (i_cmd.scan) begin
            r_rd_vld <= issue;
            r_hit    <= r_hit || hit_now;
            if (issue) begin
                r_scan_k <= r_scan_k + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key       <= i_value;
            r_scan_addr <= r_front;
        end else if (issue) begin
            r_scan_addr <= scan_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (act != bdq_pkg::ACT_SEARCH)) begin
            r_status <= n_status;
            r_found  <= 1'b0;
            r_occ    <= occ_wide_n[bdq_pkg::OCC_W-1:0];
        end else if (i_cmd.finish) begin
            r_status <= bdq_pkg::ST_DONE;
            r_found  <= r_hit || hit_now;
            r_occ    <= occ_wide_r[bdq_pkg::OCC_W-1:0];
        end
    end

    assign o_stat.srch = (act == bdq_pkg::ACT_SEARCH);
    assign o_stat.done = scan_done;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_occupancy = r_occ;

    `BDQ_ASSERT(a_count_bound, i_clk, i_rst_n, (r_count <= CNT_W'(CAPACITY)), "count above capacity")
    `BDQ_ASSERT(a_scan_bound, i_clk, i_rst_n, (r_scan_k <= r_count), "scan ran past held entries")
    `BDQ_ASSERT(a_no_issue_after_hit, i_clk, i_rst_n, (r_hit |-> !issue), "read issued after a hit")

endmodule

`default_nettype wire

// ===== src/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Request sequencing and result register handshake for the deque.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_deque_with_search_assert.svh"

module bdq_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    input  wire bdq_pkg::t_dp_stat i_stat,
    output bdq_pkg::t_dp_cmd       o_cmd
);

    bdq_pkg::t_state r_state, n_state;
    logic            r_out_vld, n_out_vld;
    logic            slot_free;

    assign slot_free = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= bdq_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            bdq_pkg::S_IDLE: begin
                o_s_tready = slot_free;
                o_cmd.load = i_s_tvalid && slot_free;
                if (o_cmd.load && i_stat.srch) begin
                    n_state = bdq_pkg::S_SCAN;
                end
            end
            bdq_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.done && slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = bdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
        n_out_vld = (o_cmd.load && !i_stat.srch) || o_cmd.finish ||
                    (r_out_vld && !i_m_tready);
    end

    assign o_m_tvalid = r_out_vld;

    `BDQ_ASSERT(a_search_enters_scan, i_clk, i_rst_n, ((o_cmd.load && i_stat.srch) |=> (r_state == bdq_pkg::S_SCAN)), "search did not start a scan")
    `BDQ_ASSERT(a_no_accept_in_scan, i_clk, i_rst_n, ((r_state == bdq_pkg::S_SCAN) |-> !o_s_tready), "request accepted during scan")
    `BDQ_ASSERT(a_finish_raises_valid, i_clk, i_rst_n, (o_cmd.finish |=> r_out_vld), "finished search left no result")

endmodule

`default_nettype wire

// ===== src/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of 32-bit words with a linear value search.
// ----------------------------------------------------------------------------
// Push and pop requests: result in the cycle after acceptance, one request a cycle
//   while the output register is free. Search: at most one ring store read per held
//   entry, from the front; the scan ends at a match or after the last held entry.
// Result sits in an output register; a request is taken only in a cycle where no
//   result waits or the waiting one leaves.
// Synchronous active-low reset empties the deque; store contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] value
    input  wire logic [2:0]  i_s_tuser,   // [2:0] action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata    // [1:0] status, [2] found, [7:3] occupancy
);

    bdq_pkg::t_dp_cmd  cmd;
    bdq_pkg::t_dp_stat stat;
    logic [bdq_pkg::STAT_W-1:0] status;
    logic                       found;
    logic [bdq_pkg::OCC_W-1:0]  occupancy;

    bdq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bdq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_action    (i_s_tuser),
        .i_value     (i_s_tdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_status    (status),
        .o_found     (found),
        .o_occupancy (occupancy)
    );

    assign o_m_tdata = {occupancy, found, status};

endmodule

`default_nettype wire

// ===== test/bounded_deque_with_search_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search_tb
// Streams push, pop, search and undefined requests into the deque. A built-in
// ring model predicts each response, which is checked field by field.
// Both sides idle in short random bursts, and the last stretch runs without
// idling. A directed opening covers the empty and full store and extreme
// words. Random phases that bias towards filling, draining or hovering follow it.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_deque_with_search_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DEPTH        = 16;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_REQS  = 1322;
    localparam int          QUIET_TAIL   = 150;
    localparam int          DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int unsigned TIMEOUT_NS   = 2_000_000;
    localparam logic [2:0]  ACT_CODE_MAX = 3'd7;
    localparam logic [31:0] WORD_MIN     = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX     = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] word;
    } t_req;

    typedef struct packed {
        logic [4:0] occupancy;
        logic       found;
        logic [1:0] status;
    } t_resp;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [31:0] i_s_tdata  = '0;   // [31:0] value
    logic [2:0]  i_s_tuser  = '0;   // [2:0] action
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;         // [1:0] status, [2] found, [7:3] occupancy

    t_req        req_q[$];
    t_resp       resp_q[$];
    t_req        cur_req;
    t_resp       want;
    t_resp       got;

    logic [31:0] ring[DEPTH];
    int          head_idx   = 0;
    int          held       = 0;

    logic [31:0] word_pool[8];
    logic [31:0] last_pushed = '0;

    int          send_gap   = 0;
    int          hold_cnt   = 0;
    int          n_sent     = 0;
    int          n_checked  = 0;
    int          n_hits     = 0;
    int          n_full     = 0;
    int          n_empty    = 0;
    int          errors     = 0;

    bounded_deque_with_search #(
        .CAPACITY (DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_resp deque_step(t_req r);
        t_resp res;
        int    k;
        res.status = bdq_pkg::ST_DONE;
        res.found  = 1'b0;
        case (r.action)
            bdq_pkg::ACT_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    res.status = bdq_pkg::ST_FULL;
                end else begin
                    head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    ring[head_idx] = r.word;
                    held++;
                end
            end
            bdq_pkg::ACT_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    res.status = bdq_pkg::ST_FULL;
                end else begin
                    ring[(head_idx + held) % DEPTH] = r.word;
                    held++;
                end
            end
            bdq_pkg::ACT_POP_FRONT: begin
                if (held == 0) begin
                    res.status = bdq_pkg::ST_EMPTY;
                end else begin
                    head_idx = (head_idx + 1) % DEPTH;
                    held--;
                end
            end
            bdq_pkg::ACT_POP_BACK: begin
                if (held == 0) begin
                    res.status = bdq_pkg::ST_EMPTY;
                end else begin
                    held--;
                end
            end
            bdq_pkg::ACT_SEARCH: begin
                for (k = 0; k < held; k++) begin
                    if (ring[(head_idx + k) % DEPTH] == r.word) begin
                        res.found = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        res.occupancy = 5'(held);
        return res;
    endfunction

    task automatic add_req(input logic [2:0] act, input logic [31:0] w);
        t_req r;
        r.action = act;
        r.word   = w;
        req_q.push_back(r);
        if (act == bdq_pkg::ACT_PUSH_FRONT || act == bdq_pkg::ACT_PUSH_BACK) begin
            last_pushed = w;
        end
    endtask

    function automatic logic [31:0] pick_word(int reuse_pct);
        if ($urandom_range(0, 99) >= reuse_pct) begin
            return $urandom;
        end
        if ($urandom_range(0, 3) == 0) begin
            return last_pushed;
        end
        return word_pool[$urandom_range(0, 7)];
    endfunction

    // request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                resp_q.push_back(deque_step(cur_req));
                n_sent++;
                if (req_q.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 4);
                end
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    cur_req = req_q.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= cur_req.word;
                    i_s_tuser  <= cur_req.action;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // response side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got = t_resp'(o_m_tdata);
                n_checked++;
                if (resp_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response, actual 0x%02h", $time, o_m_tdata);
                end else begin
                    want = resp_q.pop_front();
                    if (got.found) n_hits++;
                    if (got.status == bdq_pkg::ST_FULL) n_full++;
                    if (got.status == bdq_pkg::ST_EMPTY) n_empty++;
                    if (got.status != want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.found != want.found) begin
                        errors++;
                        $display("%0t: found expected %0d actual %0d",
                                 $time, want.found, got.found);
                    end
                    if (got.occupancy != want.occupancy) begin
                        errors++;
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occupancy, got.occupancy);
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else if (req_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
                hold_cnt = $urandom_range(0, 3);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("bounded_deque_with_search_tb NOT OK");
        $finish;
    end

    initial begin
        int          n;
        int          k;
        int          bias;
        int          run_len;
        int          r;
        int          push_pct;
        logic [2:0]  act;

        word_pool[0] = '0;
        word_pool[1] = '1;
        word_pool[2] = WORD_MIN;
        word_pool[3] = WORD_MAX;
        for (k = 4; k < 8; k++) begin
            word_pool[k] = $urandom;
        end

        // empty store, undefined codes, extreme words, fill to full
        add_req(bdq_pkg::ACT_SEARCH, '0);
        add_req(bdq_pkg::ACT_POP_FRONT, $urandom);
        add_req(bdq_pkg::ACT_POP_BACK, $urandom);
        add_req(bdq_pkg::ACT_SEARCH + 3'd1, $urandom);
        add_req(ACT_CODE_MAX, $urandom);
        add_req(bdq_pkg::ACT_PUSH_FRONT, WORD_MIN);
        add_req(bdq_pkg::ACT_PUSH_BACK, WORD_MAX);
        add_req(bdq_pkg::ACT_SEARCH, WORD_MIN);
        add_req(bdq_pkg::ACT_SEARCH, '0);
        for (k = 0; k < DEPTH - 2; k++) begin
            add_req(k[0] ? bdq_pkg::ACT_PUSH_FRONT : bdq_pkg::ACT_PUSH_BACK,
                    word_pool[k % 8] ^ k);
        end
        add_req(bdq_pkg::ACT_PUSH_FRONT, '1);
        add_req(bdq_pkg::ACT_PUSH_BACK, $urandom);
        add_req(bdq_pkg::ACT_SEARCH, last_pushed);
        add_req(bdq_pkg::ACT_POP_FRONT, '0);
        add_req(bdq_pkg::ACT_POP_BACK, '1);

        // random phases biased to fill, drain or hover
        n = 0;
        while (n < RANDOM_REQS) begin
            bias     = $urandom_range(0, 2);
            push_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
            run_len  = $urandom_range(8, 40);
            for (k = 0; k < run_len && n < RANDOM_REQS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    act = 3'($urandom_range(bdq_pkg::ACT_SEARCH + 1, ACT_CODE_MAX));
                    add_req(act, $urandom);
                end else if (r < 25) begin
                    add_req(bdq_pkg::ACT_SEARCH, pick_word(60));
                end else if ($urandom_range(0, 99) < push_pct) begin
                    act = $urandom_range(0, 1) ? bdq_pkg::ACT_PUSH_FRONT
                                               : bdq_pkg::ACT_PUSH_BACK;
                    add_req(act, pick_word(40));
                end else begin
                    act = $urandom_range(0, 1) ? bdq_pkg::ACT_POP_FRONT
                                               : bdq_pkg::ACT_POP_BACK;
                    add_req(act, $urandom);
                end
                n++;
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (resp_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests and checked %0d responses.", n_sent, n_checked);
        $display("Seen %0d search hits, %0d pushes dropped when full, %0d pops when empty.",
                 n_hits, n_full, n_empty);
        if (errors == 0) begin
            $display("bounded_deque_with_search_tb OK");
        end else begin
            $display("bounded_deque_with_search_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
